/* hw/rtl/ggxps_pkg.sv */
// Shared types and constants for the GGX prefilter sample generator.
// Used by the divide/square-root unit, the CORDIC unit and the top level.
package ggxps_pkg;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } t_ds_op;

    typedef struct packed {
        logic       start;
        t_ds_op     op;
        logic [5:0] steps;
    } t_ds_req;

    localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;
    localparam logic [30:0]        HALF_Q30        = 31'h2000_0000;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [21:0]        LOG2_SIX_Q16    = 22'd169408;
    localparam logic [22:0]        TEN_Q16         = 23'd655360;
    localparam logic [31:0]        FOUR_PI_E4_Q32  = 32'd5397215;
    localparam logic [23:0]        INV_SAT         = 24'hFF_FFFF;
    localparam int                 MAX_RESULTS     = 16;

    // arctangent of 2^-i in 1/65536 turn units
    function automatic logic [13:0] turn_atan(input logic [3:0] idx);
        logic [13:0] v;
        case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/ggxps_divsqrt.sv */
// Shared iterative unit: restoring division or integer square root, one bit per cycle.
// Depends on ggxps_pkg (request struct, op codes).
module ggxps_divsqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ggxps_pkg::t_ds_req i_req,
    input  logic [31:0]        i_rem0,
    input  logic [63:0]        i_num,
    input  logic [31:0]        i_den,
    output logic               o_busy,
    output logic [31:0]        o_q
);
    import ggxps_pkg::*;

    logic [33:0] r_rem;
    logic [63:0] r_num;
    logic [31:0] r_q;
    logic [31:0] r_den;
    t_ds_op      r_op;
    logic [5:0]  r_left;
    logic        r_busy;

    logic [33:0] shifted;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
        if (r_op == DS_SQRT) begin
            shifted = {r_rem[31:0], r_num[63:62]};
            trial   = {r_q, 2'b01};
        end else begin
            shifted = {r_rem[32:0], r_num[63]};
            trial   = {2'b00, r_den};
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_rem  <= {2'b00, i_rem0};
            r_num  <= i_num;
            r_den  <= i_den;
            r_q    <= '0;
            r_op   <= i_req.op;
            r_left <= i_req.steps;
            r_busy <= (i_req.steps != 6'd0);
        end else if (r_busy) begin
            r_rem  <= ge ? (shifted - trial) : shifted;
            r_q    <= {r_q[30:0], ge};
            r_num  <= (r_op == DS_SQRT) ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
            r_left <= r_left - 6'd1;
            if (r_left == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

endmodule

/* hw/rtl/ggxps_log2.sv */
// Iterative base-2 logarithm in Q16: leading-one search then 16 squaring steps.
// Depends on ggxps_pkg.
module ggxps_log2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_busy,
    output logic [21:0] o_result
);
    import ggxps_pkg::*;

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ
    } t_lstate;

    t_lstate     r_state;
    logic [63:0] r_x;
    logic [5:0]  r_msb;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic [3:0]  r_cnt;

    logic [63:0] sq;
    logic [32:0] sq_s;

    always_comb begin
        sq   = {32'b0, r_m} * {32'b0, r_m};
        sq_s = sq[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_msb   <= '0;
            r_frac  <= '0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_msb  <= 6'd63;
                        r_frac <= '0;
                        r_x    <= i_x;
                        if (i_x == 64'd0) begin
                            r_msb <= 6'd0;
                        end else begin
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_x[63:56] == 8'd0) begin
                        r_x   <= {r_x[55:0], 8'd0};
                        r_msb <= r_msb - 6'd8;
                    end else if (!r_x[63]) begin
                        r_x   <= {r_x[62:0], 1'b0};
                        r_msb <= r_msb - 6'd1;
                    end else begin
                        r_m     <= r_x[63:32];
                        r_cnt   <= 4'd15;
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    // square the mantissa; an overflow past 2.0 yields the next fraction bit
                    r_m    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
                    r_frac <= {r_frac[14:0], sq_s[32]};
                    r_cnt  <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != L_IDLE);
    assign o_result = {r_msb, r_frac};

endmodule

/* hw/rtl/ggxps_cordic.sv */
// Iterative 15-step CORDIC giving cos and sin (Q30) of an angle in 1/65536 turns.
// Depends on ggxps_pkg (gain constant, arctangent table).
module ggxps_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_ang,
    output logic               o_busy,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);
    import ggxps_pkg::*;

    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [16:0] r_z;
    logic [1:0]         r_q;
    logic [3:0]         r_step;
    logic               r_busy;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [16:0] atan;

    always_comb begin
        dx   = r_y >>> r_step;
        dy   = r_x >>> r_step;
        atan = $signed({3'b000, turn_atan(r_step)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({3'b000, i_ang[13:0]});
            r_q    <= i_ang[15:14];
            r_step <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (!r_z[16]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan;
            end
            r_step <= r_step + 4'd1;
            if (r_step == 4'd14) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quadrant fold
    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

    assign o_busy = r_busy;

endmodule

/* hw/rtl/ggx_prefilter_sample_generator_top.sv */
// Top level of the GGX prefilter sample generator: sequencer, multiplier and result buffer.
// Depends on ggxps_pkg, ggxps_divsqrt, ggxps_log2 and ggxps_cordic.

// For each roughness item the block walks SAMPLES*CANDIDATE_FACTOR Hammersley candidates
// and emits one result per accepted sample (light direction z above zero), up to
// min(SAMPLES,16); the last result carries the sample count and the reciprocal of the
// summed dir_z, and an item with no accepted sample gives a single empty result. One item
// is worked at a time and the input is stalled meanwhile. Most of the work on a candidate
// lies in the shared divide/square-root unit and the log2 unit, and an item ends with a
// final reciprocal. A finished result waits in an output register while work continues.
// resolution_log2 is written through the config port; it is to be written only while the
// block is idle, which the block itself does not enforce, and it resets to 8.
module ggx_prefilter_sample_generator_top #(
    parameter int SAMPLES          = 16,
    parameter int CANDIDATE_FACTOR = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [16:0]        i_roughness,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic [14:0]        o_dir_z,
    output logic signed [16:0] o_mip_level,
    output logic               o_sample_valid,
    output logic [23:0]        o_inv_total_weight,
    output logic [4:0]         o_sample_count,
    output logic               o_last
);
    import ggxps_pkg::*;

    localparam int NCAND     = SAMPLES * CANDIDATE_FACTOR;
    localparam int I_W       = $clog2(NCAND + 1);
    localparam int K_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CAP       = (SAMPLES < MAX_RESULTS) ? SAMPLES : MAX_RESULTS;
    localparam int ANG_STEP  = 65536 / SAMPLES;
    localparam int ANG_REM   = 65536 % SAMPLES;
    localparam logic [34:0] MIP_C = 35'((SAMPLES + 1) * FOUR_PI_E4_Q32);

    typedef enum logic [4:0] {
        S_IDLE, S_R2, S_A2, S_A2W, S_LOGR, S_CAND, S_E, S_DIV, S_LZ, S_SQC, S_SQS,
        S_EE, S_EE2, S_T, S_LOGT, S_X0, S_X1, S_X2, S_Y1, S_Y2, S_PUSH, S_NEXT,
        S_END, S_INV, S_FIN, S_EMPTY
    } t_state;

    t_state              r_state;
    logic [3:0]          r_res;
    logic [16:0]         r_r;
    logic [54:0]         r_a2q54;
    logic [21:0]         r_log2r;
    logic [I_W-1:0]      r_i;
    logic [K_W-1:0]      r_k;
    logic [15:0]         r_ang;
    logic [6:0]          r_angrem;
    logic [30:0]         r_e;
    logic [30:0]         r_c2;
    logic [30:0]         r_ct;
    logic [30:0]         r_st;
    logic [63:0]         r_t;
    logic signed [16:0]  r_mip;
    logic signed [15:0]  r_lx;
    logic signed [15:0]  r_ly;
    logic [4:0]          r_count;
    logic [19:0]         r_sumz;
    logic [23:0]         r_inv;
    logic signed [63:0]  r_prod;
    logic                r_have_pend;
    logic signed [15:0]  r_p_dir_x;
    logic signed [15:0]  r_p_dir_y;
    logic [14:0]         r_p_dir_z;
    logic signed [16:0]  r_p_mip;
    logic                r_o_valid;

    // unit hookup
    t_ds_req             ds_req;
    logic [31:0]         ds_rem0;
    logic [63:0]         ds_num;
    logic [31:0]         ds_den;
    logic                ds_busy;
    logic [31:0]         ds_q;
    logic                lg_start;
    logic [63:0]         lg_x;
    logic                lg_busy;
    logic [21:0]         lg_res;
    logic                cd_start;
    logic                cd_busy;
    logic signed [32:0]  cd_cos;
    logic signed [32:0]  cd_sin;

    logic signed [34:0]  mul_a;
    logic signed [34:0]  mul_b;
    logic signed [69:0]  mul_p;
    logic [15:0]         y;
    logic [15:0]         i16;
    logic [30:0]         a2q30;
    logic [30:0]         e_c;
    logic [30:0]         rem0_c2;
    logic [63:0]         t_c;
    logic                out_free;
    logic                r_nz;
    logic                lz_pos;
    logic [31:0]         lzv;
    logic [14:0]         dz;
    logic signed [26:0]  v;
    logic signed [19:0]  vs;
    logic signed [16:0]  mip_c;
    logic signed [18:0]  lxf;
    logic signed [15:0]  lxs;
    logic [6:0]          angrem_sum;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] a);
        logic signed [15:0] res;
        if (a > 19'sd32767) begin
            res = 16'sh7FFF;
        end else if (a < -19'sd32768) begin
            res = -16'sd32768;
        end else begin
            res = a[15:0];
        end
        return res;
    endfunction

    ggxps_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_rem0  (ds_rem0),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_busy  (ds_busy),
        .o_q     (ds_q)
    );

    ggxps_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lg_start),
        .i_x      (lg_x),
        .o_busy   (lg_busy),
        .o_result (lg_res)
    );

    ggxps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_ang   (r_ang),
        .o_busy  (cd_busy),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    always_comb begin
        // Hammersley y: 16-bit bit reversal of the candidate index
        i16 = 16'(r_i);
        for (int b = 0; b < 16; b++) begin
            y[b] = i16[15-b];
        end
        a2q30    = r_a2q54[54:24];
        e_c      = ONE_Q30 - r_prod[46:16];
        rem0_c2  = {(17'h10000 - {1'b0, y}), 13'b0}[30:0];
        t_c      = r_t + {10'b0, r_prod[63:10]};
        out_free = !r_o_valid || !i_out_stall;
        r_nz     = (r_r != 17'd0);
        lz_pos   = (r_c2 > HALF_Q30);
        lzv      = {r_c2, 1'b0} - {1'b0, ONE_Q30};
        dz       = (lzv[31:15] > 17'd32767) ? 15'h7FFF : lzv[29:15];
        v        = $signed(27'(LOG2_SIX_Q16)) + $signed(27'({r_res, 17'b0}))
                 + $signed(27'({r_log2r, 2'b00})) - $signed(27'(TEN_Q16))
                 - $signed(27'(lg_res));
        vs       = v[26:7];
        if (vs > 20'sd65535) begin
            mip_c = 17'sd65535;
        end else if (vs < -20'sd65536) begin
            mip_c = -17'sd65536;
        end else begin
            mip_c = vs[16:0];
        end
        lxf        = r_prod[63:45];
        lxs        = sat16(lxf);
        angrem_sum = r_angrem + 7'(ANG_REM);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_R2: begin
                mul_a = $signed({18'b0, r_r});
                mul_b = $signed({18'b0, r_r});
            end
            S_A2: begin
                mul_a = $signed({2'b0, r_prod[32:0]});
                mul_b = $signed({12'b0, r_prod[32:10]});
            end
            S_CAND: begin
                mul_a = $signed({4'b0, ONE_Q30 - a2q30});
                mul_b = $signed({19'b0, y});
            end
            S_EE: begin
                mul_a = $signed({4'b0, r_e});
                mul_b = $signed({4'b0, r_e});
            end
            S_EE2: begin
                mul_a = $signed({2'b0, r_a2q54[54:22]});
                mul_b = $signed(MIP_C);
            end
            S_X0, S_X2: begin
                mul_a = (r_state == S_X0) ? {{2{cd_cos[32]}}, cd_cos}
                                          : {{2{cd_sin[32]}}, cd_sin};
                mul_b = $signed({4'b0, r_st});
            end
            S_X1, S_Y1: begin
                mul_a = $signed({3'b0, r_ct, 1'b0});
                mul_b = $signed({r_prod[63], r_prod[63:30]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // unit start requests
    always_comb begin
        ds_req   = '{start: 1'b0, op: DS_DIV, steps: 6'd31};
        ds_rem0  = '0;
        ds_num   = '0;
        ds_den   = '0;
        lg_start = 1'b0;
        lg_x     = '0;
        cd_start = 1'b0;
        case (r_state)
            S_A2W: begin
                lg_start = r_nz;
                lg_x     = {47'b0, r_r};
            end
            S_E: begin
                ds_req.start = ({1'b0, rem0_c2} < {1'b0, e_c});
                ds_rem0      = {2'b0, rem0_c2[29:0]};
                ds_den       = {1'b0, e_c};
            end
            S_LZ: begin
                ds_req   = '{start: lz_pos, op: DS_SQRT, steps: 6'd31};
                ds_num   = {1'b0, r_c2, 32'b0};
                cd_start = lz_pos;
            end
            S_SQC: begin
                ds_req = '{start: !ds_busy, op: DS_SQRT, steps: 6'd31};
                ds_num = {1'b0, ONE_Q30 - r_c2, 32'b0};
            end
            S_T: begin
                lg_start = r_nz;
                lg_x     = t_c;
            end
            S_END: begin
                ds_req = '{start: (r_count != 5'd0), op: DS_DIV, steps: 6'd32};
                ds_num = 64'h8000_0000_0000_0000;
                ds_den = {12'b0, r_sumz};
            end
            default: begin
                ds_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= 4'd8;
            r_o_valid   <= 1'b0;
            r_have_pend <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_res <= i_cfg_data;
            end
            if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            r_prod <= mul_p[63:0];
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_r         <= (i_roughness > 17'h10000) ? 17'h10000 : i_roughness;
                        r_i         <= '0;
                        r_k         <= '0;
                        r_ang       <= '0;
                        r_angrem    <= '0;
                        r_count     <= '0;
                        r_sumz      <= '0;
                        r_have_pend <= 1'b0;
                        r_state     <= S_R2;
                    end
                end
                S_R2: r_state <= S_A2;
                S_A2: r_state <= S_A2W;
                S_A2W: begin
                    r_a2q54 <= r_prod[54:0];
                    r_log2r <= '0;
                    r_state <= r_nz ? S_LOGR : S_CAND;
                end
                S_LOGR: begin
                    if (!lg_busy) begin
                        r_log2r <= lg_res;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: r_state <= S_E;
                S_E: begin
                    r_e <= e_c;
                    if ({1'b0, rem0_c2} >= {1'b0, e_c}) begin
                        r_c2    <= ONE_Q30;
                        r_state <= S_LZ;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!ds_busy) begin
                        r_c2    <= (ds_q[30:0] > ONE_Q30) ? ONE_Q30 : ds_q[30:0];
                        r_state <= S_LZ;
                    end
                end
                S_LZ: r_state <= lz_pos ? S_SQC : S_NEXT;
                S_SQC: begin
                    if (!ds_busy) begin
                        r_ct    <= ds_q[30:0];
                        r_state <= S_SQS;
                    end
                end
                S_SQS: begin
                    if (!ds_busy) begin
                        r_st    <= ds_q[30:0];
                        r_state <= S_EE;
                    end
                end
                S_EE: r_state <= S_EE2;
                S_EE2: begin
                    r_t     <= 64'(SAMPLES) * {6'b0, r_prod[63:6]};
                    r_state <= S_T;
                end
                S_T: begin
                    r_t   <= t_c;
                    r_mip <= '0;
                    r_state <= r_nz ? S_LOGT : S_X0;
                end
                S_LOGT: begin
                    if (!lg_busy) begin
                        r_mip   <= mip_c;
                        r_state <= S_X0;
                    end
                end
                S_X0: begin
                    if (!cd_busy) begin
                        r_state <= S_X1;
                    end
                end
                S_X1: r_state <= S_X2;
                S_X2: begin
                    r_lx    <= lxs;
                    r_state <= S_Y1;
                end
                S_Y1: r_state <= S_Y2;
                S_Y2: begin
                    r_ly    <= lxs;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // a held sample goes out once the next one proves it is not the last
                    if (!r_have_pend || out_free) begin
                        if (r_have_pend) begin
                            r_o_valid          <= 1'b1;
                            o_dir_x            <= r_p_dir_x;
                            o_dir_y            <= r_p_dir_y;
                            o_dir_z            <= r_p_dir_z;
                            o_mip_level        <= r_p_mip;
                            o_sample_valid     <= 1'b1;
                            o_inv_total_weight <= '0;
                            o_sample_count     <= '0;
                            o_last             <= 1'b0;
                        end
                        r_p_dir_x   <= r_lx;
                        r_p_dir_y   <= r_ly;
                        r_p_dir_z   <= dz;
                        r_p_mip     <= r_mip;
                        r_have_pend <= 1'b1;
                        r_count     <= r_count + 5'd1;
                        r_sumz      <= r_sumz + {5'b0, dz};
                        r_state     <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_i <= r_i + I_W'(1);
                    if (r_k == K_W'(SAMPLES - 1)) begin
                        r_k      <= '0;
                        r_ang    <= '0;
                        r_angrem <= '0;
                    end else begin
                        r_k <= r_k + K_W'(1);
                        if (angrem_sum >= 7'(SAMPLES)) begin
                            r_angrem <= angrem_sum - 7'(SAMPLES);
                            r_ang    <= r_ang + 16'(ANG_STEP) + 16'd1;
                        end else begin
                            r_angrem <= angrem_sum;
                            r_ang    <= r_ang + 16'(ANG_STEP);
                        end
                    end
                    if ((r_count == 5'(CAP)) || (r_i + I_W'(1) == I_W'(NCAND))) begin
                        r_state <= S_END;
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_END: r_state <= (r_count == 5'd0) ? S_EMPTY : S_INV;
                S_INV: begin
                    if (!ds_busy) begin
                        r_inv   <= (ds_q > {8'b0, INV_SAT}) ? INV_SAT : ds_q[23:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_valid          <= 1'b1;
                        o_dir_x            <= r_p_dir_x;
                        o_dir_y            <= r_p_dir_y;
                        o_dir_z            <= r_p_dir_z;
                        o_mip_level        <= r_p_mip;
                        o_sample_valid     <= 1'b1;
                        o_inv_total_weight <= r_inv;
                        o_sample_count     <= r_count;
                        o_last             <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_o_valid          <= 1'b1;
                        o_dir_x            <= '0;
                        o_dir_y            <= '0;
                        o_dir_z            <= '0;
                        o_mip_level        <= '0;
                        o_sample_valid     <= 1'b0;
                        o_inv_total_weight <= INV_SAT;
                        o_sample_count     <= '0;
                        o_last             <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took an item but did not go busy");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sample_valid |-> o_last && (o_sample_count == 5'd0))
        else $error("empty result must be the only and last one");

    a_totals_on_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (o_sample_count == 5'd0) && (o_inv_total_weight == 24'd0))
        else $error("totals shown on a result that is not last");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(CAP))
        else $error("sample count beyond cap");
`endif

endmodule
